/* hw/rtl/u8u16dec_pkg.sv */
// Package for the UTF-8 to UTF-16 stream decoder.
// Holds the shared types, constants and lead-byte and offset functions.
// No dependencies.
`default_nettype none

package u8u16dec_pkg;

   localparam int FifoDepth = 8;
   localparam int FifoAw    = $clog2(FifoDepth);
   localparam int FifoCw    = $clog2(FifoDepth + 1);

   localparam logic [15:0] ReplacementChar   = 16'hFFFD;
   localparam logic [31:0] BmpMax            = 32'h0000_FFFF;
   localparam logic [31:0] CodeMax           = 32'h0010_FFFF;
   localparam logic [31:0] SupplementaryBase = 32'h0001_0000;
   localparam logic [15:0] SurrogateFirst    = 16'hD800;
   localparam logic [15:0] SurrogateLast     = 16'hDFFF;
   localparam logic [15:0] HighSurrBase      = 16'hD800;
   localparam logic [15:0] LowSurrBase       = 16'hDC00;
   localparam logic [9:0]  TenBitMask        = 10'h3FF;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        last_of_run;
   } unit_type;

   typedef struct packed {
      logic [1:0] count;
      unit_type   first;
      unit_type   second;
   } units_type;

   function automatic logic [2:0] trailing_count(input logic [7:0] lead);
      logic [2:0] n;
      priority if (lead < 8'hC0) n = 3'd0;
      else if (lead < 8'hE0)     n = 3'd1;
      else if (lead < 8'hF0)     n = 3'd2;
      else if (lead < 8'hF8)     n = 3'd3;
      else if (lead < 8'hFC)     n = 3'd4;
      else                       n = 3'd5;
      return n;
   endfunction

   function automatic logic [31:0] seq_offset(input logic [2:0] extra);
      logic [31:0] ofs;
      unique case (extra)
         3'd0:    ofs = 32'h0000_0000;
         3'd1:    ofs = 32'h0000_3080;
         3'd2:    ofs = 32'h000E_2080;
         3'd3:    ofs = 32'h03C8_2080;
         3'd4:    ofs = 32'hFA08_2080;
         default: ofs = 32'h8208_2080;
      endcase
      return ofs;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/utf8_to_utf16_stream_decoder.sv */
// UTF-8 to UTF-16 stream decoder, top level.
// Instantiates the accumulator, the encoder and the result queue; uses u8u16dec_pkg.
//
// The decoder accepts one UTF-8 byte per cycle while req_ready is high and
// emits UTF-16 code units one per cycle while rsp_valid and rsp_ready are
// high. A closing byte's first unit passes the value register and the result
// queue; a surrogate pair leaves as two units. Input is held off only when
// the eight-entry result queue, with the value still in flight, could not
// take another pair, so the input keeps one byte per cycle while results are
// taken at the rate they are produced. Continuation bytes are not checked.
`default_nettype none

module utf8_to_utf16_stream_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_in_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_code_unit,
   output logic             rsp_last_of_run
);
   import u8u16dec_pkg::*;

   logic              byte_accept;
   logic              value_valid;
   logic [31:0]       value;
   units_type         units;
   unit_type          head;
   logic [FifoCw-1:0] level;
   logic [FifoCw-1:0] level_limit;

   assign level_limit = value_valid ? FifoCw'(FifoDepth - 4) : FifoCw'(FifoDepth - 2);
   assign req_ready   = (level <= level_limit);
   assign byte_accept = req_valid && req_ready;

   u8u16dec_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .in_byte     (req_in_byte),
      .value_valid (value_valid),
      .value       (value)
   );

   u8u16dec_encode u_encode (
      .value_valid_data (value),
      .value_valid      (value_valid),
      .units            (units)
   );

   u8u16dec_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .units     (units),
      .pop       (rsp_ready),
      .not_empty (rsp_valid),
      .head      (head),
      .level     (level)
   );

   assign rsp_code_unit   = head.code_unit;
   assign rsp_last_of_run = head.last_of_run;

endmodule

`default_nettype wire

/* hw/rtl/u8u16dec_accum.sv */
// Byte accumulator stage of the UTF-8 to UTF-16 stream decoder.
// Tracks the open sequence and registers the finished code point value.
// Depends on u8u16dec_pkg.
`default_nettype none

module u8u16dec_accum (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        byte_accept,
   input  wire logic [7:0]  in_byte,
   output logic             value_valid,
   output logic [31:0]      value
);
   import u8u16dec_pkg::*;

   logic [31:0] acc_ff, acc_in;
   logic        in_seq_ff, in_seq_in;
   logic [2:0]  rem_ff, rem_in;
   logic [2:0]  extra_ff, extra_in;
   logic        value_valid_ff, value_valid_in;
   logic [31:0] value_ff, value_in;

   logic [2:0]  rem_cur;
   logic [2:0]  extra_cur;
   logic [31:0] sum;

   always_comb begin
      rem_cur   = in_seq_ff ? rem_ff : trailing_count(in_byte);
      extra_cur = in_seq_ff ? extra_ff : trailing_count(in_byte);
      sum       = acc_ff + {24'd0, in_byte};

      acc_in         = acc_ff;
      in_seq_in      = in_seq_ff;
      rem_in         = rem_ff;
      extra_in       = extra_ff;
      value_valid_in = 1'b0;
      value_in       = value_ff;

      if (byte_accept) begin
         if (rem_cur != 3'd0) begin
            acc_in    = {sum[25:0], 6'd0};
            rem_in    = rem_cur - 3'd1;
            extra_in  = extra_cur;
            in_seq_in = 1'b1;
         end else begin
            value_in       = sum - seq_offset(extra_cur);
            value_valid_in = 1'b1;
            acc_in         = '0;
            rem_in         = '0;
            extra_in       = '0;
            in_seq_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff         <= '0;
         in_seq_ff      <= 1'b0;
         rem_ff         <= '0;
         extra_ff       <= '0;
         value_valid_ff <= 1'b0;
      end else begin
         acc_ff         <= acc_in;
         in_seq_ff      <= in_seq_in;
         rem_ff         <= rem_in;
         extra_ff       <= extra_in;
         value_valid_ff <= value_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_valid = value_valid_ff;
   assign value       = value_ff;

endmodule

`default_nettype wire

/* hw/rtl/u8u16dec_encode.sv */
// UTF-16 encoder of the UTF-8 to UTF-16 stream decoder.
// Turns a code point value into one unit, a replacement or a surrogate pair.
// Depends on u8u16dec_pkg.
`default_nettype none

module u8u16dec_encode (
   input  wire logic [31:0]                value_valid_data,
   input  wire logic                       value_valid,
   output u8u16dec_pkg::units_type         units
);
   import u8u16dec_pkg::*;

   logic [31:0] offset_value;
   logic [15:0] low_half;

   always_comb begin
      offset_value = value_valid_data - SupplementaryBase;
      low_half     = value_valid_data[15:0];
      units        = '0;

      if (value_valid) begin
         if (value_valid_data <= BmpMax) begin
            units.count             = 2'd1;
            units.first.last_of_run = 1'b1;
            if (low_half >= SurrogateFirst && low_half <= SurrogateLast) begin
               units.first.code_unit = ReplacementChar;
            end else begin
               units.first.code_unit = low_half;
            end
         end else if (value_valid_data > CodeMax) begin
            units.count             = 2'd1;
            units.first.code_unit   = ReplacementChar;
            units.first.last_of_run = 1'b1;
         end else begin
            units.count              = 2'd2;
            units.first.code_unit    = HighSurrBase + {6'd0, offset_value[19:10]};
            units.first.last_of_run  = 1'b0;
            units.second.code_unit   = LowSurrBase + {6'd0, offset_value[9:0] & TenBitMask};
            units.second.last_of_run = 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/u8u16dec_fifo.sv */
// Result queue of the UTF-8 to UTF-16 stream decoder.
// Takes up to two code units per cycle and hands out one per transaction.
// Depends on u8u16dec_pkg.
`default_nettype none

module u8u16dec_fifo (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire u8u16dec_pkg::units_type     units,
   input  wire logic                        pop,
   output logic                             not_empty,
   output u8u16dec_pkg::unit_type           head,
   output logic [u8u16dec_pkg::FifoCw-1:0]  level
);
   import u8u16dec_pkg::*;

   unit_type           mem [FifoDepth];
   logic [FifoAw-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FifoAw-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FifoCw-1:0]  count_ff, count_in;
   logic [FifoAw-1:0]  wr_ptr_next;
   logic               do_pop;

   always_comb begin
      do_pop      = pop && (count_ff != '0);
      wr_ptr_next = wr_ptr_ff + FifoAw'(1);
      wr_ptr_in   = wr_ptr_ff + FifoAw'(units.count);
      rd_ptr_in   = rd_ptr_ff + FifoAw'(do_pop);
      count_in    = count_ff + FifoCw'(units.count) - FifoCw'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (units.count != 2'd0) begin
         mem[wr_ptr_ff] <= units.first;
      end
      if (units.count == 2'd2) begin
         mem[wr_ptr_next] <= units.second;
      end
   end

   assign not_empty = (count_ff != '0);
   assign head      = mem[rd_ptr_ff];
   assign level     = count_ff;

endmodule

`default_nettype wire
